[rtl/point_mass_wall_bounce_step_top_macros.svh]
// Assertion macros used by the checker module of this block.
`ifndef POINT_MASS_WALL_BOUNCE_STEP_TOP_MACROS_SVH
`define POINT_MASS_WALL_BOUNCE_STEP_TOP_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define PMWB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define PMWB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define PMWB_ASSERT_ALWAYS_NXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pmwb_pkg.sv]
package pmwb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TS_BITS   = 16;

  localparam int TS_W   = 16;
  localparam int THR_W  = 3;
  localparam int WS_W   = 22;
  localparam int MAP_W  = 22;
  localparam int POS_W  = 22;
  localparam int VEL_W  = 23;
  localparam int AX_W   = 21;
  localparam int AY_W   = 22;
  localparam int HIT_W  = 2;
  localparam int PX_W   = 24;
  localparam int OPA_W  = 24;
  localparam int OPB_W  = 18;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int RND_W  = PROD_W - ((FRAC_BITS < TS_BITS) ? FRAC_BITS : TS_BITS);
  localparam int SUM_W  = RND_W + 1;

  localparam int IN_BITS  = TS_W + THR_W + WS_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 2 * POS_W + 2 * VEL_W + AX_W + AY_W + HIT_W + 1;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 1'b1;

  localparam logic [MAP_W-1:0] MAP_WIDTH_RST  = MAP_W'(701235);
  localparam logic [MAP_W-1:0] MAP_HEIGHT_RST = MAP_W'(393216);

  localparam logic [THR_W-1:0] THR_UP    = 3'd1;
  localparam logic [THR_W-1:0] THR_DOWN  = 3'd2;
  localparam logic [THR_W-1:0] THR_LEFT  = 3'd3;
  localparam logic [THR_W-1:0] THR_RIGHT = 3'd4;

  localparam logic signed [AY_W-1:0] GRAVITY_Q =
    AY_W'(((longint'(981) << FRAC_BITS) + 50) / 100);
  localparam logic signed [AX_W-1:0] THRUST_Q = AX_W'(longint'(15) << FRAC_BITS);
  localparam logic signed [VEL_W-1:0] TERMINAL_Q = VEL_W'(longint'(20) << FRAC_BITS);
  localparam logic signed [OPB_W-1:0] BOUNCE_NEG_Q =
    OPB_W'(-(((longint'(4) << FRAC_BITS) + 2) / 5));
  localparam logic signed [OPB_W-1:0] DAMP_Q =
    OPB_W'(((longint'(9) << FRAC_BITS) + 5) / 10);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC_X,
    ST_ACC_Y,
    ST_POS_X,
    ST_POS_Y,
    ST_POS_END,
    ST_WALL,
    ST_SIDE_X,
    ST_SIDE_Y,
    ST_SIDE_END,
    ST_VERT_Y,
    ST_VERT_X,
    ST_VERT_END,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    OPA_AX,
    OPA_AY,
    OPA_VX,
    OPA_VY
  } opa_sel_t;

  typedef enum logic [1:0] {
    OPB_TIME,
    OPB_BOUNCE,
    OPB_DAMP
  } opb_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_VX_ACC,
    WR_VY_ACC,
    WR_PX,
    WR_PY,
    WR_VX,
    WR_VY
  } wr_sel_t;

  typedef struct packed {
    logic     load;
    opa_sel_t opa;
    opb_sel_t opb;
    wr_sel_t  wr;
    logic     wall;
    logic     finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic side_now;
    logic vert_now;
    logic vert_hit;
    logic out_busy;
  } ctrl_sts_t;

endpackage

[rtl/pmwb_ctrl.sv]
module pmwb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pmwb_pkg::ctrl_sts_t  sts,
  output pmwb_pkg::ctrl_cmd_t  cmd
);

  pmwb_pkg::state_t state;
  pmwb_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pmwb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pmwb_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = pmwb_pkg::ST_ACC_X;
        end
      end
      pmwb_pkg::ST_ACC_X:   state_next = pmwb_pkg::ST_ACC_Y;
      pmwb_pkg::ST_ACC_Y:   state_next = pmwb_pkg::ST_POS_X;
      pmwb_pkg::ST_POS_X:   state_next = pmwb_pkg::ST_POS_Y;
      pmwb_pkg::ST_POS_Y:   state_next = pmwb_pkg::ST_POS_END;
      pmwb_pkg::ST_POS_END: state_next = pmwb_pkg::ST_WALL;
      pmwb_pkg::ST_WALL: begin
        priority if (sts.side_now) begin
          state_next = pmwb_pkg::ST_SIDE_X;
        end else if (sts.vert_now) begin
          state_next = pmwb_pkg::ST_VERT_Y;
        end else begin
          state_next = pmwb_pkg::ST_DONE;
        end
      end
      pmwb_pkg::ST_SIDE_X:  state_next = pmwb_pkg::ST_SIDE_Y;
      pmwb_pkg::ST_SIDE_Y:  state_next = pmwb_pkg::ST_SIDE_END;
      pmwb_pkg::ST_SIDE_END: begin
        state_next = sts.vert_hit ? pmwb_pkg::ST_VERT_Y : pmwb_pkg::ST_DONE;
      end
      pmwb_pkg::ST_VERT_Y:   state_next = pmwb_pkg::ST_VERT_X;
      pmwb_pkg::ST_VERT_X:   state_next = pmwb_pkg::ST_VERT_END;
      pmwb_pkg::ST_VERT_END: state_next = pmwb_pkg::ST_DONE;
      pmwb_pkg::ST_DONE: begin
        if (!sts.out_busy) begin
          state_next = pmwb_pkg::ST_IDLE;
        end
      end
      default: state_next = pmwb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.opa    = pmwb_pkg::OPA_AX;
    cmd.opb    = pmwb_pkg::OPB_TIME;
    cmd.wr     = pmwb_pkg::WR_NONE;
    cmd.wall   = 1'b0;
    cmd.finish = 1'b0;
    unique case (state)
      pmwb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      pmwb_pkg::ST_ACC_X: begin
        cmd.opa = pmwb_pkg::OPA_AX;
      end
      pmwb_pkg::ST_ACC_Y: begin
        cmd.opa = pmwb_pkg::OPA_AY;
        cmd.wr  = pmwb_pkg::WR_VX_ACC;
      end
      pmwb_pkg::ST_POS_X: begin
        cmd.opa = pmwb_pkg::OPA_VX;
        cmd.wr  = pmwb_pkg::WR_VY_ACC;
      end
      pmwb_pkg::ST_POS_Y: begin
        cmd.opa = pmwb_pkg::OPA_VY;
        cmd.wr  = pmwb_pkg::WR_PX;
      end
      pmwb_pkg::ST_POS_END: begin
        cmd.wr = pmwb_pkg::WR_PY;
      end
      pmwb_pkg::ST_WALL: begin
        cmd.wall = 1'b1;
      end
      pmwb_pkg::ST_SIDE_X: begin
        cmd.opa = pmwb_pkg::OPA_VX;
        cmd.opb = pmwb_pkg::OPB_BOUNCE;
      end
      pmwb_pkg::ST_SIDE_Y: begin
        cmd.opa = pmwb_pkg::OPA_VY;
        cmd.opb = pmwb_pkg::OPB_DAMP;
        cmd.wr  = pmwb_pkg::WR_VX;
      end
      pmwb_pkg::ST_SIDE_END: begin
        cmd.wr = pmwb_pkg::WR_VY;
      end
      pmwb_pkg::ST_VERT_Y: begin
        cmd.opa = pmwb_pkg::OPA_VY;
        cmd.opb = pmwb_pkg::OPB_BOUNCE;
      end
      pmwb_pkg::ST_VERT_X: begin
        cmd.opa = pmwb_pkg::OPA_VX;
        cmd.opb = pmwb_pkg::OPB_DAMP;
        cmd.wr  = pmwb_pkg::WR_VY;
      end
      pmwb_pkg::ST_VERT_END: begin
        cmd.wr = pmwb_pkg::WR_VX;
      end
      pmwb_pkg::ST_DONE: begin
        cmd.finish = !sts.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[rtl/pmwb_dp.sv]
module pmwb_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [pmwb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pmwb_pkg::MAP_W-1:0]           cfg_data,
  input  logic [pmwb_pkg::IN_W-1:0]            in_data,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [pmwb_pkg::OUT_W-1:0]           out_data,
  input  pmwb_pkg::ctrl_cmd_t                  cmd,
  output pmwb_pkg::ctrl_sts_t                  sts
);

  localparam int TS_LSB  = 0;
  localparam int THR_LSB = TS_LSB + pmwb_pkg::TS_W;
  localparam int WS_LSB  = THR_LSB + pmwb_pkg::THR_W;

  logic [pmwb_pkg::MAP_W-1:0]          map_width;
  logic [pmwb_pkg::MAP_W-1:0]          map_height;

  logic [pmwb_pkg::TS_W-1:0]           time_step;
  logic signed [pmwb_pkg::WS_W-1:0]    wall_speed;
  logic signed [pmwb_pkg::AX_W-1:0]    acc_x;
  logic signed [pmwb_pkg::AY_W-1:0]    acc_y;
  logic signed [pmwb_pkg::AX_W-1:0]    acc_x_next;
  logic signed [pmwb_pkg::AY_W-1:0]    acc_y_next;

  logic [pmwb_pkg::POS_W-1:0]          position_x;
  logic [pmwb_pkg::POS_W-1:0]          position_y;
  logic signed [pmwb_pkg::VEL_W-1:0]   velocity_x;
  logic signed [pmwb_pkg::VEL_W-1:0]   velocity_y;

  logic signed [pmwb_pkg::VEL_W-1:0]   vx;
  logic signed [pmwb_pkg::VEL_W-1:0]   vy;
  logic signed [pmwb_pkg::PX_W-1:0]    px;
  logic signed [pmwb_pkg::PX_W-1:0]    py;
  logic [pmwb_pkg::HIT_W-1:0]          side_hit;
  logic                                vert_hit;

  logic signed [pmwb_pkg::OPA_W-1:0]   opa;
  logic signed [pmwb_pkg::OPB_W-1:0]   opb;
  logic signed [pmwb_pkg::PROD_W-1:0]  prod;
  logic                                prod_time;
  logic signed [pmwb_pkg::PROD_W-1:0]  bias_time;
  logic signed [pmwb_pkg::PROD_W-1:0]  bias_frac;
  logic signed [pmwb_pkg::RND_W-1:0]   rnd;

  logic signed [pmwb_pkg::SUM_W-1:0]   vx_sum;
  logic signed [pmwb_pkg::SUM_W-1:0]   vy_sum;
  logic signed [pmwb_pkg::SUM_W-1:0]   px_sum;
  logic signed [pmwb_pkg::SUM_W-1:0]   py_sum;
  logic signed [pmwb_pkg::PX_W-1:0]    map_w_ext;
  logic signed [pmwb_pkg::PX_W-1:0]    map_h_ext;
  logic                                left_now;
  logic                                right_now;

  function automatic logic signed [pmwb_pkg::VEL_W-1:0] clamp_term(
    input logic signed [pmwb_pkg::SUM_W-1:0] v
  );
    logic signed [pmwb_pkg::SUM_W-1:0] lim;
    lim = pmwb_pkg::SUM_W'(pmwb_pkg::TERMINAL_Q);
    if (v > lim) begin
      return pmwb_pkg::TERMINAL_Q;
    end else if (v < -lim) begin
      return -pmwb_pkg::TERMINAL_Q;
    end
    return pmwb_pkg::VEL_W'(v);
  endfunction

  function automatic logic signed [pmwb_pkg::VEL_W-1:0] sat_vel(
    input logic signed [pmwb_pkg::RND_W-1:0] v
  );
    logic signed [pmwb_pkg::RND_W-1:0] hi;
    logic signed [pmwb_pkg::RND_W-1:0] lo;
    hi = pmwb_pkg::RND_W'({1'b0, {(pmwb_pkg::VEL_W - 1){1'b1}}});
    lo = -hi - pmwb_pkg::RND_W'(1);
    if (v > hi) begin
      return {1'b0, {(pmwb_pkg::VEL_W - 1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(pmwb_pkg::VEL_W - 1){1'b0}}};
    end
    return pmwb_pkg::VEL_W'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= pmwb_pkg::MAP_WIDTH_RST;
      map_height <= pmwb_pkg::MAP_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pmwb_pkg::CFG_MAP_WIDTH:  map_width  <= cfg_data;
        pmwb_pkg::CFG_MAP_HEIGHT: map_height <= cfg_data;
        default: map_width <= map_width;
      endcase
    end
  end

  always_comb begin
    acc_x_next = '0;
    acc_y_next = pmwb_pkg::GRAVITY_Q;
    unique case (in_data[THR_LSB +: pmwb_pkg::THR_W])
      pmwb_pkg::THR_UP:    acc_y_next = pmwb_pkg::GRAVITY_Q - pmwb_pkg::AY_W'(pmwb_pkg::THRUST_Q);
      pmwb_pkg::THR_DOWN:  acc_y_next = pmwb_pkg::GRAVITY_Q + pmwb_pkg::AY_W'(pmwb_pkg::THRUST_Q);
      pmwb_pkg::THR_LEFT:  acc_x_next = -pmwb_pkg::THRUST_Q;
      pmwb_pkg::THR_RIGHT: acc_x_next = pmwb_pkg::THRUST_Q;
      default:             acc_x_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      time_step  <= in_data[TS_LSB +: pmwb_pkg::TS_W];
      wall_speed <= $signed(in_data[WS_LSB +: pmwb_pkg::WS_W]);
      acc_x      <= acc_x_next;
      acc_y      <= acc_y_next;
    end
  end

  always_comb begin
    unique case (cmd.opa)
      pmwb_pkg::OPA_AX: opa = pmwb_pkg::OPA_W'(acc_x);
      pmwb_pkg::OPA_AY: opa = pmwb_pkg::OPA_W'(acc_y);
      pmwb_pkg::OPA_VX: opa = pmwb_pkg::OPA_W'(vx);
      pmwb_pkg::OPA_VY: opa = pmwb_pkg::OPA_W'(vy);
      default:          opa = '0;
    endcase
    unique case (cmd.opb)
      pmwb_pkg::OPB_TIME:   opb = pmwb_pkg::OPB_W'($signed({1'b0, time_step}));
      pmwb_pkg::OPB_BOUNCE: opb = pmwb_pkg::BOUNCE_NEG_Q;
      pmwb_pkg::OPB_DAMP:   opb = pmwb_pkg::DAMP_Q;
      default:              opb = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod      <= opa * opb;
    prod_time <= (cmd.opb == pmwb_pkg::OPB_TIME);
  end

  // Round to nearest with ties toward plus infinity: add half an LSB, then floor.
  always_comb begin
    bias_time = prod + $signed(pmwb_pkg::PROD_W'(longint'(1) << (pmwb_pkg::TS_BITS - 1)));
    bias_frac = prod + $signed(pmwb_pkg::PROD_W'(longint'(1) << (pmwb_pkg::FRAC_BITS - 1)));
    rnd = prod_time ? pmwb_pkg::RND_W'(bias_time >>> pmwb_pkg::TS_BITS)
                    : pmwb_pkg::RND_W'(bias_frac >>> pmwb_pkg::FRAC_BITS);
    vx_sum = pmwb_pkg::SUM_W'(velocity_x) + pmwb_pkg::SUM_W'(rnd);
    vy_sum = pmwb_pkg::SUM_W'(velocity_y) + pmwb_pkg::SUM_W'(rnd);
    px_sum = pmwb_pkg::SUM_W'($signed({1'b0, position_x})) + pmwb_pkg::SUM_W'(rnd);
    py_sum = pmwb_pkg::SUM_W'($signed({1'b0, position_y})) + pmwb_pkg::SUM_W'(rnd);
  end

  always_comb begin
    map_w_ext = $signed({{(pmwb_pkg::PX_W - pmwb_pkg::MAP_W){1'b0}}, map_width});
    map_h_ext = $signed({{(pmwb_pkg::PX_W - pmwb_pkg::MAP_W){1'b0}}, map_height});
    left_now  = px < 0;
    right_now = px > map_w_ext;
    sts.side_now = left_now || right_now;
    sts.vert_now = (py < 0) || (py > map_h_ext);
    sts.vert_hit = vert_hit;
    sts.out_busy = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.wall) begin
      side_hit <= {right_now, left_now};
      vert_hit <= sts.vert_now;
    end
    if (cmd.wall && right_now) begin
      vx <= vx - pmwb_pkg::VEL_W'(wall_speed);
    end else if (cmd.wr == pmwb_pkg::WR_VX_ACC) begin
      vx <= clamp_term(vx_sum);
    end else if (cmd.wr == pmwb_pkg::WR_VX) begin
      vx <= sat_vel(rnd);
    end
    if (cmd.wr == pmwb_pkg::WR_VY_ACC) begin
      vy <= clamp_term(vy_sum);
    end else if (cmd.wr == pmwb_pkg::WR_VY) begin
      vy <= sat_vel(rnd);
    end
    if (cmd.wr == pmwb_pkg::WR_PX) begin
      px <= pmwb_pkg::PX_W'(px_sum);
    end
    if (cmd.wr == pmwb_pkg::WR_PY) begin
      py <= pmwb_pkg::PX_W'(py_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_x <= '0;
      position_y <= '0;
      velocity_x <= '0;
      velocity_y <= '0;
    end else begin
      if (cmd.wall) begin
        priority if (left_now) begin
          position_x <= '0;
        end else if (right_now) begin
          position_x <= map_width;
        end else begin
          position_x <= px[pmwb_pkg::POS_W-1:0];
        end
        priority if (py < 0) begin
          position_y <= '0;
        end else if (py > map_h_ext) begin
          position_y <= map_height;
        end else begin
          position_y <= py[pmwb_pkg::POS_W-1:0];
        end
      end
      if (cmd.finish) begin
        velocity_x <= vx;
        velocity_y <= vy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data <= pmwb_pkg::OUT_W'({vert_hit, side_hit, acc_y, acc_x, vy, vx,
                                    position_y, position_x});
    end
  end

endmodule

[rtl/point_mass_wall_bounce_step_top.sv]
// Point mass in a box: one semi-implicit Euler step for each request.
// A request on the s_axis channel carries a time step, a thruster code and the
// speed of the movable right wall. The block updates velocity, then position,
// clamps the position to the box and applies the wall and floor bounces, and
// returns one result on the m_axis channel with the new position, velocity,
// the acceleration used and the hit flags. The user sets the box size through
// the cfg port only while no request is in flight; the block does not enforce
// this. All products go through one shared 24 x 18 multiplier, one product a
// cycle. A request runs the acceleration, position and wall-check states, then
// the side bounce states if a side wall is hit, the floor or ceiling bounce
// states if one of those is hit, and the done state that registers the result.
// One request is worked on at a time; s_axis_tready is high only when idle.
// The result sits in an output register: a stalled receiver holds it there and
// the next request is still taken, but that request waits in its last step
// until the register is free.
// Reset clears position and velocity to zero, loads the default box size and
// drops the result valid signal.
module point_mass_wall_bounce_step_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [pmwb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pmwb_pkg::MAP_W-1:0]           cfg_data,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // time_step[15:0], thruster[18:16], wall_speed[40:19], zero fill above
  input  logic [pmwb_pkg::IN_W-1:0]            s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // pos_x[21:0], pos_y[43:22], vel_x[66:44], vel_y[89:67], acc_x[110:90],
  // acc_y[132:111], side_hit[134:133], vertical_hit[135]
  output logic [pmwb_pkg::OUT_W-1:0]           m_axis_tdata
);

  pmwb_pkg::ctrl_cmd_t cmd;
  pmwb_pkg::ctrl_sts_t sts;

  pmwb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pmwb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

[rtl/pmwb_chk.sv]
`include "point_mass_wall_bounce_step_top_macros.svh"

module pmwb_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [pmwb_pkg::OUT_W-1:0]  m_axis_tdata
);

  localparam int AX_LSB  = 2 * pmwb_pkg::POS_W + 2 * pmwb_pkg::VEL_W;
  localparam int HIT_LSB = AX_LSB + pmwb_pkg::AX_W + pmwb_pkg::AY_W;

  logic [pmwb_pkg::AX_W-1:0]  acc_x;
  logic [pmwb_pkg::HIT_W-1:0] side_hit;

  assign acc_x    = m_axis_tdata[AX_LSB +: pmwb_pkg::AX_W];
  assign side_hit = m_axis_tdata[HIT_LSB +: pmwb_pkg::HIT_W];

  `PMWB_ASSERT_ALWAYS_NXT(a_reset_drops_result, clk, rst, !m_axis_tvalid,
    "result valid right after reset")
  `PMWB_ASSERT_NXT(a_busy_after_accept, clk, rst, s_axis_tvalid && s_axis_tready,
    !s_axis_tready, "new request taken while one is in flight")
  `PMWB_ASSERT_NXT(a_stalled_result_holds, clk, rst, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed or dropped")
  `PMWB_ASSERT_IMP(a_one_side_wall, clk, rst, m_axis_tvalid, side_hit != 2'b11,
    "both side walls reported hit")
  `PMWB_ASSERT_IMP(a_acc_x_legal, clk, rst, m_axis_tvalid,
    acc_x == '0 || acc_x == pmwb_pkg::THRUST_Q || acc_x == -pmwb_pkg::THRUST_Q,
    "horizontal acceleration is not zero or plus or minus thrust")

endmodule

bind point_mass_wall_bounce_step_top pmwb_chk u_pmwb_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
